// File: rtl/pid_controller_anti_windup_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared helpers for the concurrent checks of the PID controller.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTI_WINDUP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PIDAW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Types, constants and fixed-point helpers shared by the PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int STEP_BITS  = 16;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int QUO_WIDTH  = DATA_WIDTH + STEP_BITS;
   localparam int RND_WIDTH  = PROD_WIDTH - FRAC_BITS;
   localparam int CNT_WIDTH  = $clog2(QUO_WIDTH);
   localparam int ADDR_WIDTH = 5;

   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_DRIVE_LOW  = 3'd3;
   localparam logic [2:0] REG_DRIVE_HIGH = 3'd4;
   localparam logic [2:0] REG_ACCUM_LOW  = 3'd5;
   localparam logic [2:0] REG_ACCUM_HIGH = 3'd6;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] gain_p;
      logic signed [DATA_WIDTH-1:0] gain_i;
      logic signed [DATA_WIDTH-1:0] gain_d;
      logic signed [DATA_WIDTH-1:0] drive_low;
      logic signed [DATA_WIDTH-1:0] drive_high;
      logic signed [DATA_WIDTH-1:0] accum_low;
      logic signed [DATA_WIDTH-1:0] accum_high;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_PROP,
      MUL_DERIV,
      MUL_INC,
      MUL_CAND,
      MUL_ACCUM
   } mul_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_DIV_END,
      ST_P_MUL,
      ST_P_RND,
      ST_D_MUL,
      ST_D_RND,
      ST_INC_MUL,
      ST_INC_RND,
      ST_CAND,
      ST_CI_MUL,
      ST_CI_RND,
      ST_COMMIT,
      ST_I_MUL,
      ST_I_RND,
      ST_SUM,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic        load;
      logic        div_init;
      logic        div_step;
      logic        div_end;
      logic        mul_en;
      logic        rnd_en;
      mul_sel_type mul_sel;
      logic        cand;
      logic        commit;
      logic        sum;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic have_last;
      logic step_nz;
      logic integ;
      logic div_last;
   } dp_status_type;

   function automatic logic signed [DATA_WIDTH-1:0] sat_wide(
      input logic signed [DATA_WIDTH:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      if (v > $signed({SMAX[DATA_WIDTH-1], SMAX})) r = SMAX;
      else if (v < $signed({SMIN[DATA_WIDTH-1], SMIN})) r = SMIN;
      else r = v[DATA_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      return sat_wide($signed({a[DATA_WIDTH-1], a}) + $signed({b[DATA_WIDTH-1], b}));
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      return sat_wide($signed({a[DATA_WIDTH-1], a}) - $signed({b[DATA_WIDTH-1], b}));
   endfunction

   // A value below lo gives lo first, so with crossed limits a value below lo gives lo and any other hi.
   function automatic logic signed [DATA_WIDTH-1:0] clamp(
      input logic signed [DATA_WIDTH-1:0] v, input logic signed [DATA_WIDTH-1:0] lo,
      input logic signed [DATA_WIDTH-1:0] hi);
      logic signed [DATA_WIDTH-1:0] r;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // Applies a sign to a magnitude and saturates to the signed data range.
   function automatic logic signed [DATA_WIDTH-1:0] sign_sat(
      input logic neg, input logic [RND_WIDTH-1:0] m);
      logic [RND_WIDTH-1:0] lim;
      logic [RND_WIDTH-1:0] c;
      lim = neg ? (RND_WIDTH'(1) << (DATA_WIDTH - 1)) : RND_WIDTH'(SMAX);
      c   = (m > lim) ? lim : m;
      return neg ? -$signed(c[DATA_WIDTH-1:0]) : $signed(c[DATA_WIDTH-1:0]);
   endfunction

   // Drops the fraction bits of a product, rounding half away from zero.
   function automatic logic signed [DATA_WIDTH-1:0] round_sat(
      input logic signed [PROD_WIDTH-1:0] p);
      logic                  neg;
      logic [PROD_WIDTH-1:0] m;
      neg = p[PROD_WIDTH-1];
      m   = neg ? PROD_WIDTH'(-p) : PROD_WIDTH'(p);
      m   = m + (PROD_WIDTH'(1) << (FRAC_BITS - 1));
      return sign_sat(neg, m[PROD_WIDTH-1:FRAC_BITS]);
   endfunction

endpackage

// File: rtl/pidaw_csr.sv
// ----------------------------------------------------------------------------
// PID controller register bank
// Holds gains and limits, written and read over the configuration port.
// ----------------------------------------------------------------------------
module pidaw_csr
   import pidaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= '0;
         cfg_ff.gain_i     <= '0;
         cfg_ff.gain_d     <= '0;
         cfg_ff.drive_low  <= SMIN;
         cfg_ff.drive_high <= SMAX;
         cfg_ff.accum_low  <= SMIN;
         cfg_ff.accum_high <= SMAX;
      end else if (wr_en) begin
         unique case (idx)
            REG_GAIN_P:     cfg_ff.gain_p     <= csr_pwdata;
            REG_GAIN_I:     cfg_ff.gain_i     <= csr_pwdata;
            REG_GAIN_D:     cfg_ff.gain_d     <= csr_pwdata;
            REG_DRIVE_LOW:  cfg_ff.drive_low  <= csr_pwdata;
            REG_DRIVE_HIGH: cfg_ff.drive_high <= csr_pwdata;
            REG_ACCUM_LOW:  cfg_ff.accum_low  <= csr_pwdata;
            REG_ACCUM_HIGH: cfg_ff.accum_high <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GAIN_P:     csr_prdata = cfg_ff.gain_p;
         REG_GAIN_I:     csr_prdata = cfg_ff.gain_i;
         REG_GAIN_D:     csr_prdata = cfg_ff.gain_d;
         REG_DRIVE_LOW:  csr_prdata = cfg_ff.drive_low;
         REG_DRIVE_HIGH: csr_prdata = cfg_ff.drive_high;
         REG_ACCUM_LOW:  csr_prdata = cfg_ff.accum_low;
         REG_ACCUM_HIGH: csr_prdata = cfg_ff.accum_high;
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/pidaw_dp.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Error, derivative divider, shared multiplier and anti-windup accumulator.
// ----------------------------------------------------------------------------
module pidaw_dp
   import pidaw_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  dp_cmd_type                   cmd,
   input  logic                         in_op,
   input  logic signed [DATA_WIDTH-1:0] in_setpoint,
   input  logic signed [DATA_WIDTH-1:0] in_feedback,
   input  logic [STEP_BITS-1:0]         in_step_time,
   input  logic                         in_integrate_on,
   output dp_status_type                status,
   output logic signed [DATA_WIDTH-1:0] drive
);

   logic signed [DATA_WIDTH-1:0] acc_ff, last_ff, err_ff, deriv_ff;
   logic signed [DATA_WIDTH-1:0] prop_ff, dterm_ff, inc_ff, cand_ff, ci_ff, iterm_ff;
   logic signed [DATA_WIDTH-1:0] res_ff, drive_ff;
   logic                         have_last_ff, integ_ff, neg_ff;
   logic [STEP_BITS-1:0]         dt_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [DATA_WIDTH-1:0] op_a, op_b, rnd, diff, pd, cout;
   logic [QUO_WIDTH-1:0]         dvd_ff;
   logic [STEP_BITS:0]           rem_ff, rem_sh;
   logic [CNT_WIDTH-1:0]         cnt_ff;
   logic                         fit;

   assign status.have_last = have_last_ff;
   assign status.step_nz   = (dt_ff != '0);
   assign status.integ     = integ_ff;
   assign status.div_last  = (cnt_ff == CNT_WIDTH'(QUO_WIDTH - 1));
   assign drive            = drive_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_PROP:  begin op_a = cfg.gain_p; op_b = err_ff; end
         MUL_DERIV: begin op_a = cfg.gain_d; op_b = deriv_ff; end
         MUL_INC:   begin op_a = err_ff; op_b = $signed(DATA_WIDTH'(dt_ff)); end
         MUL_CAND:  begin op_a = cfg.gain_i; op_b = cand_ff; end
         MUL_ACCUM: begin op_a = cfg.gain_i; op_b = acc_ff; end
         default:   begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_in = PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);
   assign rnd     = round_sat(prod_ff);
   assign diff    = sat_sub(err_ff, last_ff);
   assign pd      = sat_add(prop_ff, dterm_ff);
   assign cout    = sat_add(pd, ci_ff);
   // Restoring division: one quotient bit a cycle, quotient shifts into dvd_ff.
   assign rem_sh  = {rem_ff[STEP_BITS-1:0], dvd_ff[QUO_WIDTH-1]};
   assign fit     = (rem_sh >= {1'b0, dt_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.rnd_en) begin
         unique case (cmd.mul_sel)
            MUL_PROP:  prop_ff  <= rnd;
            MUL_DERIV: dterm_ff <= rnd;
            MUL_INC:   inc_ff   <= rnd;
            MUL_CAND:  ci_ff    <= rnd;
            MUL_ACCUM: iterm_ff <= rnd;
            default: ;
         endcase
      end
      if (cmd.load) begin
         err_ff   <= sat_sub(in_setpoint, in_feedback);
         dt_ff    <= in_step_time;
         integ_ff <= in_integrate_on;
         deriv_ff <= '0;
      end
      if (cmd.div_init) begin
         neg_ff <= diff[DATA_WIDTH-1];
         dvd_ff <= {(diff[DATA_WIDTH-1] ? -diff : diff), {STEP_BITS{1'b0}}};
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= fit ? rem_sh - {1'b0, dt_ff} : rem_sh;
         dvd_ff <= {dvd_ff[QUO_WIDTH-2:0], fit};
         cnt_ff <= cnt_ff + CNT_WIDTH'(1);
      end
      if (cmd.div_end) deriv_ff <= sign_sat(neg_ff, RND_WIDTH'(dvd_ff));
      if (cmd.cand) cand_ff <= clamp(sat_add(acc_ff, inc_ff), cfg.accum_low, cfg.accum_high);
      if (cmd.sum) res_ff <= clamp(sat_add(pd, iterm_ff), cfg.drive_low, cfg.drive_high);
      if (cmd.load && in_op == OP_CLEAR) res_ff <= '0;
      if (cmd.out_load) drive_ff <= res_ff;
   end

   // Controller state of the loop: cleared by reset and by a clear request.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
      end else if (cmd.load && in_op == OP_CLEAR) begin
         acc_ff       <= '0;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
      end else begin
         // The candidate is dropped when the output would saturate the way
         // the error already pushes it.
         if (cmd.commit && !((cout > cfg.drive_high && err_ff > 0) ||
                             (cout < cfg.drive_low && err_ff < 0)))
            acc_ff <= cand_ff;
         if (cmd.sum) begin
            last_ff      <= err_ff;
            have_last_ff <= 1'b1;
         end
      end
   end

endmodule

// File: rtl/pidaw_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps the datapath through one update and owns both stream handshakes.
// ----------------------------------------------------------------------------
`include "pid_controller_anti_windup_defines.svh"

module pidaw_ctrl
   import pidaw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_op,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_PROP;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = (req_op == OP_CLEAR) ? ST_DONE : ST_START;
            end
         end
         ST_START: state_in = (status.have_last && status.step_nz) ? ST_DIV_INIT : ST_P_MUL;
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_P_MUL;
         end
         ST_P_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_P_RND;
         end
         ST_P_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = ST_D_MUL;
         end
         ST_D_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DERIV;
            state_in    = ST_D_RND;
         end
         ST_D_RND: begin
            cmd.rnd_en  = 1'b1;
            cmd.mul_sel = MUL_DERIV;
            state_in    = (status.integ && status.step_nz) ? ST_INC_MUL : ST_I_MUL;
         end
         ST_INC_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INC;
            state_in    = ST_INC_RND;
         end
         ST_INC_RND: begin
            cmd.rnd_en  = 1'b1;
            cmd.mul_sel = MUL_INC;
            state_in    = ST_CAND;
         end
         ST_CAND: begin
            cmd.cand = 1'b1;
            state_in = ST_CI_MUL;
         end
         ST_CI_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CAND;
            state_in    = ST_CI_RND;
         end
         ST_CI_RND: begin
            cmd.rnd_en  = 1'b1;
            cmd.mul_sel = MUL_CAND;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_I_MUL;
         end
         ST_I_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ACCUM;
            state_in    = ST_I_RND;
         end
         ST_I_RND: begin
            cmd.rnd_en  = 1'b1;
            cmd.mul_sel = MUL_ACCUM;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait here while an earlier result is still unclaimed.
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `PIDAW_ASSERT_IMP(a_out_no_overwrite, clock, reset, cmd.out_load, !out_valid_ff || rsp_tready, "result register overwritten before transfer")
   `PIDAW_ASSERT_NEXT(a_clear_to_done, clock, reset, accept && req_op == OP_CLEAR, state_ff == ST_DONE, "clear request did not go straight to result")
   `PIDAW_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == ST_DIV_RUN && status.div_last, state_ff == ST_DIV_END, "divider did not finish after its last step")
   `PIDAW_ASSERT_IMP(a_div_needs_step, clock, reset, state_ff == ST_DIV_INIT, status.step_nz && status.have_last, "derivative started without a time step or previous error")

endmodule

// File: rtl/pid_controller_anti_windup.sv
// A clear request goes straight to the result; an update takes the derivative only when a
// previous error is held and the step time is nonzero.
// The derivative divide retires one quotient bit per cycle, 48 bits in all; the single
// shared 32x32 multiplier registers then rounds each product, up to five per update.
// One item is in work at a time: a new transfer is taken only once the last result is loaded.
// Synchronous reset restores the register defaults and clears accumulator and previous error.
// ----------------------------------------------------------------------------
// PID controller with conditional-integration anti-windup
// Signed Q16.16 PID step with clamped accumulator and output, stream ports.
// ----------------------------------------------------------------------------
module pid_controller_anti_windup
   import pidaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // setpoint [31:0], feedback [63:32], step_time [79:64], integrate_on [80], zero [87:81]
   input  logic [87:0]           req_tdata,
   // op [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drive [31:0]
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type                      cfg;
   dp_cmd_type                   cmd;
   dp_status_type                status;
   logic signed [DATA_WIDTH-1:0] drive;

   pidaw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidaw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pidaw_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .in_op           (req_tuser),
      .in_setpoint     ($signed(req_tdata[31:0])),
      .in_feedback     ($signed(req_tdata[63:32])),
      .in_step_time    (req_tdata[79:64]),
      .in_integrate_on (req_tdata[80]),
      .status          (status),
      .drive           (drive)
   );

   assign rsp_tdata = drive;

endmodule
